/* rtl/wma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_pkg
// Shared constants, types and the reciprocal table of the centre-weighted
// moving average row filter.
// ----------------------------------------------------------------------------
package wma_pkg;

   localparam int MAX_HALF = 31;
   localparam int SAMPLE_W = 24;
   localparam int HALF_W   = 5;
   localparam int ADDR_W   = $clog2(2 * MAX_HALF + 2);
   localparam int DEPTH    = 1 << ADDR_W;
   localparam int CNT_W    = ADDR_W + 1;
   localparam int DIV_W    = ADDR_W + 1;
   localparam int SUM_W    = SAMPLE_W + ADDR_W;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic [HALF_W-1:0]          half_type;
   typedef logic [SUM_W-1:0]           psum_type;
   typedef logic [CNT_W-1:0]           count_type;

   typedef struct packed {
      logic       en;
      addr_type   addr;
      sample_type sample;
      psum_type   prefix;
   } store_wr_type;

   typedef struct packed {
      logic      valid;
      half_type  centre;
      half_type  half;
      logic      last;
      addr_type  newest;
      count_type count;
   } job_type;

   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] total;
      half_type                half;
      logic                    last;
   } total_type;

   // floor(2^(SUM_W-1) / (n+1)), i.e. floor(2^SUM_W / 2(n+1))
   localparam psum_type RECIP_TABLE [0:MAX_HALF] = '{
      30'd536870912, 30'd268435456, 30'd178956970, 30'd134217728,
      30'd107374182, 30'd89478485,  30'd76695844,  30'd67108864,
      30'd59652323,  30'd53687091,  30'd48806446,  30'd44739242,
      30'd41297762,  30'd38347922,  30'd35791394,  30'd33554432,
      30'd31580641,  30'd29826161,  30'd28256363,  30'd26843545,
      30'd25565281,  30'd24403223,  30'd23342213,  30'd22369621,
      30'd21474836,  30'd20648881,  30'd19884107,  30'd19173961,
      30'd18512790,  30'd17895697,  30'd17318416,  30'd16777216
   };

endpackage

/* rtl/wma_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_req_if
// Sample channel: one row sample and its end-of-row mark per word.
// ----------------------------------------------------------------------------
interface wma_req_if;
   import wma_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;
   logic       row_end;

   modport source (output valid, output sample, output row_end, input ready);
   modport sink (input valid, input sample, input row_end, output ready);

endinterface

/* rtl/wma_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_rsp_if
// Result channel: one smoothed sample and its last-of-row mark per word.
// ----------------------------------------------------------------------------
interface wma_rsp_if;
   import wma_pkg::*;

   logic       valid;
   logic       ready;
   sample_type smoothed;
   logic       last_of_row;

   modport source (output valid, output smoothed, output last_of_row, input ready);
   modport sink (input valid, input smoothed, input last_of_row, output ready);

endinterface

/* rtl/wma_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_ctrl
// Takes in samples, keeps the running prefix sum and row counters, and
// issues smoothing jobs to the window datapath, taking no new sample while a job waits.
// ----------------------------------------------------------------------------
module wma_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wma_pkg::sample_type   req_sample,
   input  logic                  req_row_end,
   input  logic                  csr_wr_en,
   input  wma_pkg::half_type     csr_wr_data,
   input  logic                  advance,
   output wma_pkg::store_wr_type store_wr,
   output wma_pkg::job_type      job
);
   import wma_pkg::*;

   half_type  half_ff, half_in;
   addr_type  wp_ff, wp_in;
   psum_type  acc_ff, acc_in;
   count_type count_ff, count_in;
   half_type  pend_ff, pend_in;
   logic      busy_ff, busy_in;
   half_type  centre_ff, centre_in;
   logic      flush_ff, flush_in;

   half_type  n_cur;
   logic      accept;
   logic      issue;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign issue     = busy_ff && advance;
   assign n_cur     = (int'(half_ff) > MAX_HALF) ? HALF_W'(MAX_HALF) : half_ff;

   assign store_wr.en     = accept;
   assign store_wr.addr   = wp_ff;
   assign store_wr.sample = req_sample;
   assign store_wr.prefix = acc_ff + SUM_W'(req_sample);

   assign job.valid  = busy_ff;
   assign job.centre = centre_ff;
   assign job.half   = n_cur;
   assign job.last   = flush_ff && (centre_ff == '0);
   assign job.newest = wp_ff - 1'b1;
   assign job.count  = count_ff;

   always_comb begin
      half_in   = csr_wr_en ? csr_wr_data : half_ff;
      wp_in     = wp_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      busy_in   = busy_ff;
      centre_in = centre_ff;
      flush_in  = flush_ff;
      if (accept) begin
         wp_in     = wp_ff + 1'b1;
         acc_in    = req_row_end ? '0 : store_wr.prefix;
         centre_in = pend_ff;
         flush_in  = req_row_end;
         if (count_ff != CNT_W'(DEPTH)) begin
            count_in = count_ff + 1'b1;
         end
         if (req_row_end || (pend_ff >= n_cur)) begin
            busy_in = 1'b1;
         end else begin
            pend_in = pend_ff + 1'b1;
         end
      end
      if (issue) begin
         if (flush_ff && (centre_ff != '0)) begin
            centre_in = centre_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
         // close the row after its final result
         if (flush_ff && (centre_ff == '0)) begin
            pend_in  = '0;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff   <= '0;
         wp_ff     <= '0;
         acc_ff    <= '0;
         count_ff  <= '0;
         pend_ff   <= '0;
         busy_ff   <= 1'b0;
         centre_ff <= '0;
         flush_ff  <= 1'b0;
      end else begin
         half_ff   <= half_in;
         wp_ff     <= wp_in;
         acc_ff    <= acc_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         busy_ff   <= busy_in;
         centre_ff <= centre_in;
         flush_ff  <= flush_in;
      end
   end

endmodule

/* rtl/wma_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_window
// Sample and prefix-sum memories; forms the weighted window sum of a job
// from two prefix reads and the centre sample.
// ----------------------------------------------------------------------------
module wma_window (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  wma_pkg::store_wr_type store_wr,
   input  wma_pkg::job_type      job,
   output wma_pkg::total_type    total
);
   import wma_pkg::*;

   sample_type sample_mem [DEPTH];
   psum_type   prefix_mem [DEPTH];

   addr_type   age_lo;
   addr_type   age_top;
   addr_type   age_hi;
   count_type  wgt_full;
   addr_type   addr_x;
   addr_type   addr_top;
   addr_type   addr_base;
   logic       zero_in;

   sample_type centre_rd_ff;
   psum_type   top_rd_ff;
   psum_type   base_rd_ff;

   logic       s1_valid_ff;
   logic       s1_last_ff;
   half_type   s1_half_ff;
   logic       s1_zero_ff;
   addr_type   s1_wgt_ff;

   logic signed [SUM_W-1:0]      win_in;
   logic signed [SAMPLE_W+ADDR_W:0] xw_in;

   logic                    s2_valid_ff;
   logic                    s2_last_ff;
   half_type                s2_half_ff;
   logic signed [SUM_W-1:0] s2_win_ff;
   logic signed [SUM_W-1:0] s2_xw_ff;

   always_comb begin
      age_lo    = (job.centre >= job.half) ? ADDR_W'(job.centre - job.half) : '0;
      age_top   = ADDR_W'(job.centre) + ADDR_W'(job.half);
      age_hi    = (CNT_W'(age_top) < job.count) ? age_top
                                                 : ADDR_W'(job.count - 1'b1);
      zero_in   = (CNT_W'(age_hi) + 1'b1) == job.count;
      wgt_full  = CNT_W'({job.half, 1'b1}) - CNT_W'(age_hi) + CNT_W'(age_lo);
      addr_x    = job.newest - ADDR_W'(job.centre);
      addr_top  = job.newest - age_lo;
      addr_base = job.newest - age_hi - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         sample_mem[store_wr.addr] <= store_wr.sample;
         prefix_mem[store_wr.addr] <= store_wr.prefix;
      end
      if (advance) begin
         centre_rd_ff <= sample_mem[addr_x];
         top_rd_ff    <= prefix_mem[addr_top];
         base_rd_ff   <= prefix_mem[addr_base];
      end
   end

   always_comb begin
      win_in = top_rd_ff - (s1_zero_ff ? '0 : base_rd_ff);
      xw_in  = centre_rd_ff * $signed({1'b0, s1_wgt_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= job.valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_last_ff <= job.last;
         s1_half_ff <= job.half;
         s1_zero_ff <= zero_in;
         s1_wgt_ff  <= wgt_full[ADDR_W-1:0];
         s2_last_ff <= s1_last_ff;
         s2_half_ff <= s1_half_ff;
         s2_win_ff  <= win_in;
         s2_xw_ff   <= xw_in[SUM_W-1:0];
      end
   end

   assign total.valid = s2_valid_ff;
   assign total.total = s2_win_ff + s2_xw_ff;
   assign total.half  = s2_half_ff;
   assign total.last  = s2_last_ff;

endmodule

/* rtl/wma_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_div
// Divides the weighted sum by 2(n+1) with round to nearest, ties away from
// zero: reciprocal multiply, back-multiply and one correction step.
// ----------------------------------------------------------------------------
module wma_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  wma_pkg::total_type  total,
   output logic                rsp_valid,
   output wma_pkg::sample_type rsp_smoothed,
   output logic                rsp_last_of_row
);
   import wma_pkg::*;

   logic                    a_valid_ff;
   logic signed [SUM_W-1:0] a_sum_ff;
   half_type                a_half_ff;
   logic                    a_last_ff;

   psum_type                mag;
   psum_type                m_in;

   logic                    b_valid_ff;
   psum_type                b_m_ff;
   logic                    b_neg_ff;
   half_type                b_half_ff;
   logic                    b_last_ff;

   logic [2*SUM_W-1:0]      prod;

   logic                    c_valid_ff;
   sample_type              c_q0_ff;
   psum_type                c_m_ff;
   logic                    c_neg_ff;
   half_type                c_half_ff;
   logic                    c_last_ff;

   logic [DIV_W-1:0]        dvs_c;
   logic [SAMPLE_W+DIV_W-1:0] qd_full;

   logic                    d_valid_ff;
   psum_type                d_qd_ff;
   sample_type              d_q0_ff;
   psum_type                d_m_ff;
   logic                    d_neg_ff;
   half_type                d_half_ff;
   logic                    d_last_ff;

   logic [DIV_W-1:0]        dvs_d;
   psum_type                rem;
   logic                    inc;
   sample_type              q;
   sample_type              res_in;

   logic                    out_valid_ff;
   sample_type              out_data_ff;
   logic                    out_last_ff;

   always_comb begin
      mag     = a_sum_ff[SUM_W-1] ? psum_type'(-a_sum_ff) : psum_type'(a_sum_ff);
      m_in    = mag + SUM_W'(a_half_ff) + 1'b1;
      prod    = b_m_ff * RECIP_TABLE[b_half_ff];
      dvs_c   = {ADDR_W'(c_half_ff) + 1'b1, 1'b0};
      qd_full = c_q0_ff * dvs_c;
      dvs_d   = {ADDR_W'(d_half_ff) + 1'b1, 1'b0};
      rem     = d_m_ff - d_qd_ff;
      inc     = rem >= SUM_W'(dvs_d);
      q       = d_q0_ff + {{(SAMPLE_W-1){1'b0}}, inc};
      res_in  = d_neg_ff ? -q : q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= total.valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         out_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_sum_ff    <= total.total;
         a_half_ff   <= total.half;
         a_last_ff   <= total.last;
         b_m_ff      <= m_in;
         b_neg_ff    <= a_sum_ff[SUM_W-1];
         b_half_ff   <= a_half_ff;
         b_last_ff   <= a_last_ff;
         c_q0_ff     <= prod[SUM_W +: SAMPLE_W];
         c_m_ff      <= b_m_ff;
         c_neg_ff    <= b_neg_ff;
         c_half_ff   <= b_half_ff;
         c_last_ff   <= b_last_ff;
         d_qd_ff     <= qd_full[SUM_W-1:0];
         d_q0_ff     <= c_q0_ff;
         d_m_ff      <= c_m_ff;
         d_neg_ff    <= c_neg_ff;
         d_half_ff   <= c_half_ff;
         d_last_ff   <= c_last_ff;
         out_data_ff <= res_in;
         out_last_ff <= d_last_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_smoothed    = out_data_ff;
   assign rsp_last_of_row = out_last_ff;

endmodule

/* rtl/weighted_moving_average_row.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_moving_average_row
// Path: a released result passes the window read and s2 registers, then the
//   divider a, b, c, d and output registers. A sample that releases a result is
//   accepted, then issued as one job into the memory read port before the next
//   sample is taken; a row end flushes pending results one per cycle. A waiting
//   output word holds the job issue and the pipeline. Reset clears the half
//   width, counters and pipeline, but not the sample and prefix memories.
// ----------------------------------------------------------------------------
module weighted_moving_average_row (
   input  logic              clock,
   input  logic              reset,
   wma_req_if.sink           req_chan,
   wma_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  wma_pkg::half_type csr_wr_data
);
   import wma_pkg::*;

   logic         advance;
   store_wr_type store_wr;
   job_type      job;
   total_type    total;

   // hold every stage while the output word waits
   assign advance = !rsp_chan.valid || rsp_chan.ready;

   wma_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_sample  (req_chan.sample),
      .req_row_end (req_chan.row_end),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .store_wr    (store_wr),
      .job         (job)
   );

   wma_window u_window (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .store_wr (store_wr),
      .job      (job),
      .total    (total)
   );

   wma_div u_div (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .total           (total),
      .rsp_valid       (rsp_chan.valid),
      .rsp_smoothed    (rsp_chan.smoothed),
      .rsp_last_of_row (rsp_chan.last_of_row)
   );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives rows of Q15.8 samples through the centre-weighted moving average
// filter and checks every smoothed word and its last-of-row mark.
// A directed table covers the extremes, single-sample rows, the widest window
// and half-width changes in the middle of a row. Random rows follow, over
// several half widths. Both channels idle at random. The result side also
// holds off once for a long stretch. An in-bench model of the window predicts
// each result.
// ----------------------------------------------------------------------------
module testbench;
   import wma_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 200;
   localparam int STORE_LEN     = 2 * MAX_HALF + 1;
   localparam int PHASES        = 9;
   localparam int PHASE_WORDS   = 17;
   localparam int PRINT_CAP     = 40;
   localparam int SENDER        = 0;
   localparam int RECEIVER      = 1;
   localparam sample_type SAMPLE_MAX = sample_type'(24'h7fffff);
   localparam sample_type SAMPLE_MIN = sample_type'(24'h800000);

   typedef enum logic {ROW_WORD, SET_HALF} plan_op_type;

   typedef struct packed {
      plan_op_type op;
      sample_type  arg;
      logic        row_end;
      logic        pinned;
      sample_type  want;
      logic        want_last;
   } plan_row_type;

   typedef struct packed {
      sample_type smoothed;
      logic       last_of_row;
   } smoothed_word_type;

   localparam int PLAN_LEN = 22;
   plan_row_type plan [PLAN_LEN] = '{
      '{ROW_WORD, SAMPLE_MAX,   1'b0, 1'b1, SAMPLE_MAX,   1'b0},
      '{ROW_WORD, SAMPLE_MIN,   1'b1, 1'b1, SAMPLE_MIN,   1'b1},
      '{ROW_WORD, 24'sd0,       1'b1, 1'b1, 24'sd0,       1'b1},
      '{ROW_WORD, -24'sd1,      1'b1, 1'b1, -24'sd1,      1'b1},
      '{ROW_WORD, 24'sd1,       1'b0, 1'b1, 24'sd1,       1'b0},
      '{ROW_WORD, 24'sd256,     1'b1, 1'b1, 24'sd256,     1'b1},
      '{SET_HALF, 24'sd31,      1'b0, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, SAMPLE_MAX,   1'b0, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, SAMPLE_MIN,   1'b0, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, SAMPLE_MAX,   1'b1, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, SAMPLE_MIN,   1'b1, 1'b1, SAMPLE_MIN,   1'b1},
      '{SET_HALF, 24'sd2,       1'b0, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, 24'sd1000,    1'b0, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, -24'sd2000,   1'b0, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, 24'sd3,       1'b0, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, -24'sd5,      1'b0, 1'b0, 24'sd0,       1'b0},
      '{SET_HALF, 24'sd1,       1'b0, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, 24'sd7,       1'b0, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, -24'sd9,      1'b0, 1'b0, 24'sd0,       1'b0},
      '{SET_HALF, 24'sd3,       1'b0, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, 24'sd11,      1'b0, 1'b0, 24'sd0,       1'b0},
      '{ROW_WORD, -24'sd13,     1'b1, 1'b0, 24'sd0,       1'b0}
   };

   logic     clock = 1'b0;
   logic     reset;
   logic     csr_wr_en;
   half_type csr_wr_data;

   wma_req_if req_chan();
   wma_rsp_if rsp_chan();

   weighted_moving_average_row uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   sample_type        win_hist [STORE_LEN];
   int                row_count;
   int                held_count;
   int                half_cfg;
   smoothed_word_type smoothed_due [$];
   int                mismatch_count = 0;

   logic       cur_pinned;
   sample_type cur_want;
   logic       cur_want_last;
   bit         random_phase = 1'b0;
   logic       hold_off = 1'b0;
   int         gap_left [2] = '{0, 0};
   bit         gap_calm [2] = '{1'b0, 1'b0};

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
   endtask

   function automatic sample_type weighted_mean(input int c, input int n);
      longint centre;
      longint total;
      longint mag;
      longint q;
      int     a;
      int     k;
      centre = win_hist[c];
      total  = centre;
      for (k = -n; k <= n; k++) begin
         a = c - k;
         if (a >= 0 && a < row_count && a < STORE_LEN)
            total += win_hist[a];
         else
            total += centre;
      end
      mag = (total < 0) ? -total : total;
      q   = (mag + longint'(n + 1)) / longint'(2 * (n + 1));
      return sample_type'((total < 0) ? -q : q);
   endfunction

   task automatic advance_row(input sample_type s, input logic last);
      int n;
      int a;
      int c;
      n = (half_cfg > MAX_HALF) ? MAX_HALF : half_cfg;
      for (a = STORE_LEN - 1; a > 0; a--)
         win_hist[a] = win_hist[a-1];
      win_hist[0] = s;
      if (row_count < STORE_LEN)
         row_count++;
      if (!last) begin
         if (held_count < n)
            held_count++;
         else
            smoothed_due.push_back('{smoothed: weighted_mean(held_count, n), last_of_row: 1'b0});
      end else begin
         for (c = held_count; c >= 0; c--)
            smoothed_due.push_back('{smoothed: weighted_mean(c, n),
                                     last_of_row: (c == 0)});
         held_count = 0;
         row_count  = 0;
      end
   endtask

   function automatic int pick_gap(input int side);
      if (gap_left[side] == 0) begin
         gap_left[side] = $urandom_range(8, 24);
         gap_calm[side] = ($urandom_range(0, 2) == 0);
      end
      gap_left[side]--;
      return gap_calm[side] ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic sample_type draw_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return sample_type'($signed($urandom_range(0, 8)) - 4);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic int draw_row_len();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7)
         return $urandom_range(1, 12);
      else if (pick < 9)
         return $urandom_range(13, 40);
      else
         return $urandom_range(41, 80);
   endfunction

   task automatic send_word(input sample_type s, input logic last, input logic pinned,
                            input sample_type want, input logic want_last);
      int gap;
      gap = pick_gap(SENDER);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.sample  <= s;
      req_chan.row_end <= last;
      cur_pinned       <= pinned;
      cur_want         <= want;
      cur_want_last    <= want_last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drain_results();
      @(posedge clock);
      while (smoothed_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_half(input half_type n);
      req_chan.valid <= 1'b0;
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      half_cfg = n;
   endtask

   always @(posedge clock) begin : word_monitor
      int                due_before;
      smoothed_word_type head;
      if (!reset && req_chan.valid && req_chan.ready) begin
         due_before = smoothed_due.size();
         advance_row(req_chan.sample, req_chan.row_end);
         if (cur_pinned && smoothed_due.size() > due_before)
            smoothed_due[due_before] = '{smoothed: cur_want, last_of_row: cur_want_last};
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (smoothed_due.size() == 0) begin
            report_mismatch("result with no word pending", rsp_chan.smoothed, 0);
         end else begin
            head = smoothed_due.pop_front();
            if (rsp_chan.smoothed !== head.smoothed)
               report_mismatch("smoothed", rsp_chan.smoothed, head.smoothed);
            if (rsp_chan.last_of_row !== head.last_of_row)
               report_mismatch("last_of_row", rsp_chan.last_of_row, head.last_of_row);
         end
      end
   end

   initial begin : result_sink
      int stall;
      rsp_chan.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         stall = pick_gap(RECEIVER);
         if (stall > 0 || hold_off) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (hold_off) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin : back_pressure
      wait (random_phase);
      repeat (60) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle = 0;
         else
            idle++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      half_type sweep [PHASES];
      half_type n;
      int       sent;
      int       len;
      int       j;
      sweep = '{5'd0, 5'd0, 5'd31, 5'd0, 5'd1, 5'd31, 5'd0, 5'd2, 5'd15};
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.sample  <= '0;
      req_chan.row_end <= 1'b0;
      cur_pinned       <= 1'b0;
      cur_want         <= '0;
      cur_want_last    <= 1'b0;
      half_cfg   = 0;
      row_count  = 0;
      held_count = 0;
      for (j = 0; j < STORE_LEN; j++)
         win_hist[j] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (plan[i].op == SET_HALF)
            write_half(half_type'(plan[i].arg));
         else
            send_word(plan[i].arg, plan[i].row_end, plan[i].pinned,
                      plan[i].want, plan[i].want_last);
      end

      random_phase = 1'b1;
      for (int ph = 0; ph < PHASES; ph++) begin
         n = (ph % 3 == 0) ? half_type'($urandom_range(0, MAX_HALF)) : sweep[ph];
         write_half(n);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            len = draw_row_len();
            for (j = 0; j < len; j++)
               send_word(draw_sample(), (j == len - 1), 1'b0, '0, 1'b0);
            sent += len;
         end
      end

      req_chan.valid <= 1'b0;
      drain_results();
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
